### rtl/kic_pkg.sv
package kic_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int ENTRY_LIMIT_W = 31;
  localparam logic [ENTRY_LIMIT_W-1:0] ENTRY_LIMIT_RESET = 31'd199999999;
  localparam int DISPLAY_W = 32;
  localparam int DECIMAL_BASE = 10;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CMD_NOP    = 3'd0,
    CMD_DIGIT  = 3'd1,
    CMD_DZERO  = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_BACK   = 3'd4,
    CMD_NEG    = 3'd5,
    CMD_EQUALS = 3'd6,
    CMD_OPER   = 3'd7
  } cmd_kind_t;

  typedef enum logic [1:0] {
    UNIT_MUL = 2'd0,
    UNIT_DIV = 2'd1,
    UNIT_MOD = 2'd2
  } unit_op_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] digit;
    op_t        op;
  } cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic [3:0] digit;
  } key_t;

  typedef struct packed {
    logic signed [DISPLAY_W-1:0] display_value;
    logic                        error;
  } result_t;

endpackage

### rtl/keypad_integer_calculator_top.sv
// Channel   Direction  Handshake            Payload
// config    in         psel/penable/pready  paddr, pwdata, prdata (entry_limit)
// keys      in         push / full          key_press (func, digit)
// results   out        pop / empty          result (display_value, error)
//
// Clear, negate, equals, add, subtract, divide by zero and ignored keys go from B_IDLE to
// B_EMIT; a digit goes through B_APPEND, double zero through it twice, backspace through
// B_BACK, B_BFIX and B_BSIGN, a shift-and-add divide by ten; multiply, divide and modulo
// wait in B_WAIT for the bit-serial unit. Reset is synchronous, clears the control state,
// sets entry_limit to 199999999 and holds full high for one cycle. A two-entry command queue
// takes keys while the result waits for pop; the back end starts a command only when free.
module keypad_integer_calculator_top
  import kic_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  key_t        key_press,
  output logic        empty,
  output result_t     result,
  input  logic        pop
);

  localparam logic [2:0] REG_ENTRY_LIMIT = 3'd0;

  logic [ENTRY_LIMIT_W-1:0] entry_limit;
  logic q_full;
  logic q_wr;
  cmd_t q_wr_cmd;
  logic q_rd;
  cmd_t q_rd_cmd;
  logic q_empty;
  logic unit_start;
  unit_op_t unit_op;
  logic [DATA_WIDTH-1:0] unit_a;
  logic [DATA_WIDTH-1:0] unit_b;
  logic unit_done;
  logic [DATA_WIDTH-1:0] unit_result;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ENTRY_LIMIT) ? {1'b0, entry_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= ENTRY_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_ENTRY_LIMIT)) begin
      entry_limit <= pwdata[ENTRY_LIMIT_W-1:0];
    end
  end

  kic_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .key_press  (key_press),
    .queue_full (q_full),
    .queue_wr   (q_wr),
    .queue_cmd  (q_wr_cmd)
  );

  kic_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd     (q_rd),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  kic_serial_unit #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .op     (unit_op),
    .a      (unit_a),
    .b      (unit_b),
    .done   (unit_done),
    .result (unit_result)
  );

  kic_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_limit (entry_limit),
    .cmd_empty   (q_empty),
    .cmd         (q_rd_cmd),
    .cmd_pop     (q_rd),
    .unit_start  (unit_start),
    .unit_op     (unit_op),
    .unit_a      (unit_a),
    .unit_b      (unit_b),
    .unit_done   (unit_done),
    .unit_result (unit_result),
    .empty       (empty),
    .result      (result),
    .pop         (pop)
  );

endmodule

### rtl/kic_front.sv
module kic_front
  import kic_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  key_t key_press,
  input  logic queue_full,
  output logic queue_wr,
  output cmd_t queue_cmd
);

  typedef enum logic [3:0] {
    FUNC_DIGIT  = 4'd0,
    FUNC_DZERO  = 4'd1,
    FUNC_CLEAR  = 4'd2,
    FUNC_BACK   = 4'd3,
    FUNC_NEG    = 4'd4,
    FUNC_EQUALS = 4'd5,
    FUNC_ADD    = 4'd6,
    FUNC_SUB    = 4'd7,
    FUNC_MUL    = 4'd8,
    FUNC_DIV    = 4'd9,
    FUNC_MOD    = 4'd10
  } func_t;

  localparam logic [3:0] MAX_DIGIT = 4'd9;

  logic accepted;

  // Holds the input off for the first cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted <= 1'b0;
    end else begin
      accepted <= 1'b1;
    end
  end

  assign full = queue_full || !accepted;
  assign queue_wr = push && !full;

  always_comb begin
    queue_cmd.kind = CMD_NOP;
    queue_cmd.digit = key_press.digit;
    queue_cmd.op = OP_NONE;
    case (func_t'(key_press.func))
      FUNC_DIGIT: begin
        if (key_press.digit <= MAX_DIGIT) begin
          queue_cmd.kind = CMD_DIGIT;
        end
      end
      FUNC_DZERO:  queue_cmd.kind = CMD_DZERO;
      FUNC_CLEAR:  queue_cmd.kind = CMD_CLEAR;
      FUNC_BACK:   queue_cmd.kind = CMD_BACK;
      FUNC_NEG:    queue_cmd.kind = CMD_NEG;
      FUNC_EQUALS: queue_cmd.kind = CMD_EQUALS;
      FUNC_ADD: begin
        queue_cmd.kind = CMD_OPER;
        queue_cmd.op = OP_ADD;
      end
      FUNC_SUB: begin
        queue_cmd.kind = CMD_OPER;
        queue_cmd.op = OP_SUB;
      end
      FUNC_MUL: begin
        queue_cmd.kind = CMD_OPER;
        queue_cmd.op = OP_MUL;
      end
      FUNC_DIV: begin
        queue_cmd.kind = CMD_OPER;
        queue_cmd.op = OP_DIV;
      end
      FUNC_MOD: begin
        queue_cmd.kind = CMD_OPER;
        queue_cmd.op = OP_MOD;
      end
      default: queue_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

### rtl/kic_cmd_queue.sv
module kic_cmd_queue
  import kic_pkg::*;
#(
  parameter int DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/kic_serial_unit.sv
module kic_serial_unit
  import kic_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  unit_op_t              op,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int DW = DATA_WIDTH;
  localparam int CNT_W = $clog2(DW);

  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_FIX
  } unit_state_t;

  unit_state_t state;
  unit_op_t op_r;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0] x;
  logic [DW-1:0] y;
  logic [DW:0] z;
  logic neg_q;
  logic neg_r;

  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b;
  logic [DW:0] shifted;
  logic [DW:0] trial;
  logic fits;
  logic [DW-1:0] mul_sum;

  always_comb begin
    mag_a = a[DW-1] ? -a : a;
    mag_b = b[DW-1] ? -b : b;
    shifted = {z[DW-1:0], x[DW-1]};
    trial = shifted - {1'b0, y};
    fits = !trial[DW];
    mul_sum = z[DW-1:0] + (y[0] ? x : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            op_r <= op;
            cnt <= CNT_W'(DW - 1);
            z <= '0;
            neg_q <= a[DW-1] ^ b[DW-1];
            neg_r <= a[DW-1];
            if (op == UNIT_MUL) begin
              x <= a;
              y <= b;
            end else begin
              x <= mag_a;
              y <= mag_b;
            end
            state <= U_RUN;
          end
        end
        U_RUN: begin
          if (op_r == UNIT_MUL) begin
            z <= {1'b0, mul_sum};
            x <= x << 1;
            y <= y >> 1;
          end else begin
            z <= fits ? trial : shifted;
            x <= {x[DW-2:0], fits};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= U_FIX;
          end
        end
        U_FIX: begin
          case (op_r)
            UNIT_DIV: result <= neg_q ? -x : x;
            UNIT_MOD: result <= neg_r ? -z[DW-1:0] : z[DW-1:0];
            default:  result <= z[DW-1:0];
          endcase
          done <= 1'b1;
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

### rtl/kic_back.sv
module kic_back
  import kic_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ENTRY_LIMIT_W-1:0] entry_limit,
  input  logic                     cmd_empty,
  input  cmd_t                     cmd,
  output logic                     cmd_pop,
  output logic                     unit_start,
  output unit_op_t                 unit_op,
  output logic [DATA_WIDTH-1:0]    unit_a,
  output logic [DATA_WIDTH-1:0]    unit_b,
  input  logic                     unit_done,
  input  logic [DATA_WIDTH-1:0]    unit_result,
  output logic                     empty,
  output result_t                  result,
  input  logic                     pop
);

  localparam int DW = DATA_WIDTH;
  localparam int CMP_W = (DW > ENTRY_LIMIT_W) ? DW : ENTRY_LIMIT_W;

  typedef enum logic [2:0] {
    B_IDLE,
    B_APPEND,
    B_WAIT,
    B_EMIT,
    B_BACK,
    B_BFIX,
    B_BSIGN
  } back_state_t;

  back_state_t state;
  logic [DW-1:0] accumulator;
  logic [DW-1:0] entry_value;
  op_t pending_operator;
  logic entering_digits;
  logic divide_error;
  logic out_valid;
  logic [3:0] app_digit;
  logic app_left;
  logic [DW-1:0] bs_n;
  logic [DW-1:0] bs_q;
  logic [7:0] bs_shift;
  logic bs_neg;

  logic below_limit;
  logic [DW-1:0] appended;
  logic [DW-1:0] sum;
  logic [DW-1:0] diff;
  logic do_apply;
  logic [DW-1:0] entry_mag;
  logic [DW-1:0] bs_rem;
  logic bs_carry;

  assign cmd_pop = (state == B_IDLE) && !cmd_empty && !out_valid;
  assign empty = !out_valid;

  always_comb begin
    below_limit = entry_value[DW-1] || (CMP_W'(entry_value) < CMP_W'(entry_limit));
    appended = (entry_value << 3) + (entry_value << 1) + DW'(app_digit);
    sum = accumulator + entry_value;
    diff = accumulator - entry_value;
    do_apply = (cmd.kind == CMD_EQUALS) ||
               (entering_digits && (pending_operator != OP_NONE));
    entry_mag = entry_value[DW-1] ? -entry_value : entry_value;
    bs_rem = bs_n - ((bs_q << 3) + (bs_q << 1));
    bs_carry = (bs_rem > DW'(DECIMAL_BASE - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      accumulator <= '0;
      entry_value <= '0;
      pending_operator <= OP_NONE;
      entering_digits <= 1'b0;
      divide_error <= 1'b0;
      out_valid <= 1'b0;
      unit_start <= 1'b0;
    end else begin
      unit_start <= 1'b0;
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (cmd_pop) begin
            state <= B_EMIT;
            case (cmd.kind)
              CMD_DIGIT, CMD_DZERO: begin
                if (!entering_digits) begin
                  entry_value <= '0;
                end
                entering_digits <= 1'b1;
                app_digit <= (cmd.kind == CMD_DIGIT) ? cmd.digit : 4'd0;
                app_left <= (cmd.kind == CMD_DZERO);
                state <= B_APPEND;
              end
              CMD_CLEAR: begin
                accumulator <= '0;
                entry_value <= '0;
                pending_operator <= OP_NONE;
                entering_digits <= 1'b0;
                divide_error <= 1'b0;
              end
              CMD_BACK: begin
                bs_n <= entry_mag;
                bs_neg <= entry_value[DW-1];
                bs_shift <= '0;
                state <= B_BACK;
              end
              CMD_NEG: begin
                entry_value <= -entry_value;
              end
              CMD_EQUALS, CMD_OPER: begin
                pending_operator <= (cmd.kind == CMD_EQUALS) ? OP_NONE : cmd.op;
                entering_digits <= 1'b0;
                unit_a <= accumulator;
                unit_b <= entry_value;
                if (do_apply) begin
                  divide_error <= 1'b0;
                  case (pending_operator)
                    OP_ADD: begin
                      accumulator <= sum;
                      entry_value <= sum;
                    end
                    OP_SUB: begin
                      accumulator <= diff;
                      entry_value <= diff;
                    end
                    OP_MUL: begin
                      unit_start <= 1'b1;
                      unit_op <= UNIT_MUL;
                      state <= B_WAIT;
                    end
                    OP_DIV, OP_MOD: begin
                      if (entry_value == '0) begin
                        divide_error <= 1'b1;
                      end else begin
                        unit_start <= 1'b1;
                        unit_op <= (pending_operator == OP_DIV) ? UNIT_DIV : UNIT_MOD;
                        state <= B_WAIT;
                      end
                    end
                    default: accumulator <= entry_value;
                  endcase
                end else if (pending_operator == OP_NONE) begin
                  accumulator <= entry_value;
                end
              end
              default: state <= B_EMIT;
            endcase
          end
        end
        B_APPEND: begin
          if (below_limit) begin
            entry_value <= appended;
          end
          app_left <= 1'b0;
          if (!app_left) begin
            state <= B_EMIT;
          end
        end
        B_BACK: begin
          if (bs_shift == '0) begin
            bs_q <= (bs_n >> 1) + (bs_n >> 2);
            bs_shift <= 8'd4;
          end else if (int'(bs_shift) < DW) begin
            bs_q <= bs_q + (bs_q >> bs_shift);
            bs_shift <= bs_shift << 1;
          end else begin
            bs_q <= bs_q >> 3;
            state <= B_BFIX;
          end
        end
        B_BFIX: begin
          bs_q <= bs_q + DW'(bs_carry);
          state <= B_BSIGN;
        end
        B_BSIGN: begin
          entry_value <= bs_neg ? -bs_q : bs_q;
          state <= B_EMIT;
        end
        B_WAIT: begin
          if (unit_done) begin
            entry_value <= unit_result;
            accumulator <= unit_result;
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          result.display_value <= DISPLAY_W'(entry_value);
          result.error <= divide_error;
          out_valid <= 1'b1;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### tb/keypad_integer_calculator_top_tb.sv
`timescale 1ns / 1ps

module keypad_integer_calculator_top_tb;
  import kic_pkg::*;

  localparam logic [3:0] F_DIGIT  = 4'd0;
  localparam logic [3:0] F_DZERO  = 4'd1;
  localparam logic [3:0] F_CLEAR  = 4'd2;
  localparam logic [3:0] F_BACK   = 4'd3;
  localparam logic [3:0] F_NEG    = 4'd4;
  localparam logic [3:0] F_EQUALS = 4'd5;
  localparam logic [3:0] F_ADD    = 4'd6;
  localparam logic [3:0] F_SUB    = 4'd7;
  localparam logic [3:0] F_MUL    = 4'd8;
  localparam logic [3:0] F_DIV    = 4'd9;
  localparam logic [3:0] F_MOD    = 4'd10;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  localparam logic [2:0] ADDR_ENTRY_LIMIT = 3'd0;

  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_KEYS = 150;
  localparam int NUM_PHASES = 6;

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

  typedef struct packed {
    bit      has;
    result_t val;
  } known_t;

  typedef struct {
    key_t    k;
    bit      has;
    result_t val;
  } key_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  key_t        key_press = '0;
  logic        empty;
  result_t     result;
  logic        pop = 1'b0;

  keypad_integer_calculator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .full     (full),
    .key_press(key_press),
    .empty    (empty),
    .result   (result),
    .pop      (pop)
  );

  // Calculator state as the testbench sees it.
  logic [31:0] calc_acc;
  logic [31:0] calc_entry;
  op_t         calc_pending;
  logic        calc_entering;
  logic        calc_err;
  logic [30:0] calc_limit;

  result_t display_q[$];
  known_t  known_q[$];

  int mismatches = 0;
  int keys_taken = 0;
  int results_seen = 0;
  int error_results = 0;
  bit long_hold = 1'b0;
  bit calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] q;
    q = mag(a) / mag(b);
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] rem(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    r = mag(a) % mag(b);
    return a[31] ? -r : r;
  endfunction

  function automatic void append_digit(input logic [3:0] d);
    if (calc_entry[31] || calc_entry < {1'b0, calc_limit}) begin
      calc_entry = calc_entry * 32'd10 + {28'd0, d};
    end
  endfunction

  function automatic void apply_pending();
    calc_err = 1'b0;
    case (calc_pending)
      OP_ADD: calc_acc = calc_acc + calc_entry;
      OP_SUB: calc_acc = calc_acc - calc_entry;
      OP_MUL: calc_acc = calc_acc * calc_entry;
      OP_DIV, OP_MOD: begin
        if (calc_entry == '0) begin
          calc_err = 1'b1;
          calc_entry = '0;
          return;
        end
        calc_acc = (calc_pending == OP_DIV) ? quot(calc_acc, calc_entry)
                                            : rem(calc_acc, calc_entry);
      end
      default: calc_acc = calc_entry;
    endcase
    calc_entry = calc_acc;
  endfunction

  function automatic op_t op_of(input logic [3:0] f);
    case (f)
      F_ADD:   return OP_ADD;
      F_SUB:   return OP_SUB;
      F_MUL:   return OP_MUL;
      F_DIV:   return OP_DIV;
      default: return OP_MOD;
    endcase
  endfunction

  function automatic result_t press_key(input key_t k);
    result_t r;
    if (k.func == F_DIGIT || k.func == F_DZERO) begin
      if (k.func == F_DZERO || k.digit <= DIGIT_MAX) begin
        if (!calc_entering) begin
          calc_entry = '0;
          calc_entering = 1'b1;
        end
        if (k.func == F_DIGIT) begin
          append_digit(k.digit);
        end else begin
          append_digit(4'd0);
          append_digit(4'd0);
        end
      end
    end else if (k.func == F_CLEAR) begin
      calc_acc = '0;
      calc_entry = '0;
      calc_pending = OP_NONE;
      calc_entering = 1'b0;
      calc_err = 1'b0;
    end else if (k.func == F_BACK) begin
      calc_entry = quot(calc_entry, 32'd10);
    end else if (k.func == F_NEG) begin
      calc_entry = -calc_entry;
    end else if (k.func == F_EQUALS) begin
      apply_pending();
      calc_pending = OP_NONE;
      calc_entering = 1'b0;
    end else if (k.func <= F_MOD) begin
      if (calc_entering && calc_pending != OP_NONE) begin
        apply_pending();
      end else if (calc_pending == OP_NONE) begin
        calc_acc = calc_entry;
      end
      calc_pending = op_of(k.func);
      calc_entering = 1'b0;
    end
    r.display_value = calc_entry;
    r.error = calc_err;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    known_t  kn;
    if (rst) begin
      calc_acc = '0;
      calc_entry = '0;
      calc_pending = OP_NONE;
      calc_entering = 1'b0;
      calc_err = 1'b0;
      calc_limit = ENTRY_LIMIT_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_ENTRY_LIMIT) begin
        calc_limit = pwdata[30:0];
      end
      if (push && !full) begin
        got = press_key(key_press);
        kn = '0;
        if (known_q.size() != 0) begin
          kn = known_q.pop_front();
        end
        display_q.push_back(kn.has ? kn.val : got);
        keys_taken++;
      end
      if (pop && !empty) begin
        results_seen++;
        if (result.error) begin
          error_results++;
        end
        if (display_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result display %0d error %0b", $time,
                   result.display_value, result.error);
        end else begin
          want = display_q.pop_front();
          if (result.display_value !== want.display_value) begin
            mismatches++;
            $display("%0t: display_value expected %0d actual %0d", $time,
                     want.display_value, result.display_value);
          end
          if (result.error !== want.error) begin
            mismatches++;
            $display("%0t: error expected %0b actual %0b", $time, want.error,
                     result.error);
          end
        end
      end
    end
  end

  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        pop <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  task automatic send_key(input key_t k, input bit has, input result_t val);
    known_t kn;
    kn.has = has;
    kn.val = val;
    known_q.push_back(kn);
    push <= 1'b1;
    key_press <= k;
    do @(posedge clk); while (full);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (display_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_entry_limit(input logic [31:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ENTRY_LIMIT;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic key_t random_key();
    key_t k;
    int unsigned r;
    k.digit = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      k.func = F_DIGIT;
      k.digit = 4'($urandom_range(0, DIGIT_MAX));
    end else if (r < 45) begin
      k.func = F_DZERO;
    end else if (r < 50) begin
      k.func = F_BACK;
    end else if (r < 55) begin
      k.func = F_NEG;
    end else if (r < 65) begin
      k.func = F_EQUALS;
    end else if (r < 67) begin
      k.func = F_CLEAR;
    end else if (r < 92) begin
      k.func = 4'($urandom_range(F_ADD, F_MOD));
    end else if (r < 96) begin
      k.func = F_DIGIT;
      k.digit = 4'($urandom_range(DIGIT_MAX + 1, 15));
    end else begin
      k.func = 4'($urandom_range(F_MOD + 1, 15));
    end
    return k;
  endfunction

  function automatic key_row_t mk(input logic [3:0] f, input logic [3:0] d, input bit has,
                                  input logic [31:0] v, input logic e);
    key_row_t row;
    row.k.func = f;
    row.k.digit = d;
    row.has = has;
    row.val.display_value = v;
    row.val.error = e;
    return row;
  endfunction

  initial begin
    key_row_t    directed_keys[$];
    logic [31:0] limits[NUM_PHASES];

    directed_keys = '{
      mk(F_CLEAR, 4'd0, 1, 32'd0, 1'b0),
      mk(F_DIGIT, 4'd9, 1, 32'd9, 1'b0),
      mk(F_DZERO, 4'd0, 1, 32'd900, 1'b0),
      mk(F_NEG, 4'd0, 1, -32'd900, 1'b0),
      mk(F_BACK, 4'd0, 1, -32'd90, 1'b0),
      mk(F_ADD, 4'd0, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd7, 1, 32'd7, 1'b0),
      mk(F_SUB, 4'd0, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd3, 0, '0, 1'b0),
      mk(F_MUL, 4'd0, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd0, 1, 32'd0, 1'b0),
      mk(F_DIV, 4'd0, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd0, 1, 32'd0, 1'b0),
      mk(F_EQUALS, 4'd0, 1, 32'd0, 1'b1),
      mk(F_MOD, 4'd0, 0, '0, 1'b0),
      mk(F_EQUALS, 4'd0, 1, 32'd0, 1'b1),
      mk(F_DIGIT, 4'd12, 0, '0, 1'b0),
      mk(F_MOD + 4'd1, 4'd15, 0, '0, 1'b0),
      mk(F_CLEAR, 4'd0, 1, 32'd0, 1'b0),
      mk(F_DIGIT, 4'd2, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd1, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd4, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd7, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd4, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd8, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd3, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd6, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd4, 0, '0, 1'b0),
      mk(F_NEG, 4'd0, 0, '0, 1'b0),
      mk(F_MUL, 4'd0, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd1, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd0, 1, 32'd10, 1'b0),
      mk(F_SUB, 4'd0, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd8, 0, '0, 1'b0),
      mk(F_DIV, 4'd0, 1, MOST_NEG, 1'b0),
      mk(F_DIGIT, 4'd1, 1, 32'd1, 1'b0),
      mk(F_NEG, 4'd0, 1, MINUS_ONE, 1'b0),
      mk(F_EQUALS, 4'd0, 1, MOST_NEG, 1'b0),
      mk(F_MOD, 4'd0, 0, '0, 1'b0),
      mk(F_DIGIT, 4'd1, 1, 32'd1, 1'b0),
      mk(F_NEG, 4'd0, 1, MINUS_ONE, 1'b0),
      mk(F_EQUALS, 4'd0, 1, 32'd0, 1'b0)
    };

    limits[0] = 32'd0;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'd99;
    limits[3] = {1'b0, 31'($urandom)};
    limits[4] = 32'd1000;
    limits[5] = {1'b0, ENTRY_LIMIT_RESET};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_keys[i]) begin
      send_key(directed_keys[i].k, directed_keys[i].has, directed_keys[i].val);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_entry_limit(limits[p]);
      if (p == NUM_PHASES - 1) begin
        calm = 1'b1;
      end
      // The receiver stops popping for a while so the key queue backs up.
      if (p == 1) begin
        long_hold = 1'b1;
      end
      for (int i = 0; i < PHASE_KEYS; i++) begin
        if (p == 2 && i == PHASE_KEYS / 2) begin
          wait_drained();
        end
        send_key(random_key(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d key presses over %0d entry limit settings; %0d results checked,",
             keys_taken, NUM_PHASES + 1, results_seen);
    $display("%0d of them with the divide error set, with backpressure on both sides.",
             error_results);
    if (mismatches == 0 && display_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/kic_pkg.sv
rtl/kic_front.sv
rtl/kic_cmd_queue.sv
rtl/kic_serial_unit.sv
rtl/kic_back.sv
rtl/keypad_integer_calculator_top.sv
tb/keypad_integer_calculator_top_tb.sv
